/* hw/rtl/vicbf_pkg.sv */
`default_nettype none

package vicbf_pkg;

    localparam int COUNTERS   = 4096;
    localparam int CNT_W      = 8;
    localparam int IDX_W      = $clog2(COUNTERS);
    localparam int MAX_HASHES = 4;
    localparam int SEL_W      = $clog2(MAX_HASHES);
    localparam int NFUNC_W    = 3;
    localparam int LEXP_W     = 3;
    localparam int LEXP_MIN   = 1;
    localparam int LEXP_MAX   = 5;
    localparam int INC_W      = LEXP_MAX + 1;
    localparam int HASH_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [NFUNC_W-1:0] HASHES_RESET = NFUNC_W'(4);
    localparam logic [LEXP_W-1:0]  LEXP_RESET   = LEXP_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_HASHES_USED    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_EXPONENT = CFG_IDX_W'(1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [HASH_W-1:0] f_hash_0;
        logic [HASH_W-1:0] f_hash_1;
        logic [HASH_W-1:0] f_hash_2;
        logic [HASH_W-1:0] f_hash_3;
        logic [HASH_W-1:0] g_hash_0;
        logic [HASH_W-1:0] g_hash_1;
        logic [HASH_W-1:0] g_hash_2;
        logic [HASH_W-1:0] g_hash_3;
    } t_in;

    typedef struct packed {
        logic found;
        logic overflow_seen;
        logic underflow_seen;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             clr;
        logic [IDX_W-1:0] clr_addr;
        logic             ex;
        logic             upd;
        logic [SEL_W-1:0] sel;
        logic             emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0]         op;
        logic [NFUNC_W-1:0] nfunc;
        logic               miss;
    } t_sts;

endpackage

`default_nettype wire

/* hw/rtl/variable_increment_counting_bloom.sv */
`default_nettype none

// Variable-increment counting Bloom filter over 4096 8-bit counters held in one
// single-port RAM. After reset the block sweeps the RAM to zero, one counter a
// cycle, and holds busy high until the sweep is done; configuration writes are
// taken during the sweep. An operation is issued with start while busy is low.
// Each hash function in use takes a RAM read (ST_READ), then a check or
// read-modify-write (ST_EXEC), in each pass, since the one RAM port is shared
// across functions. Insert and lookup make one pass, remove makes a check pass
// and, if the key is found, a decrement pass. The result appears on o_res with
// o_res_strobe, which is high for exactly one cycle, the first with busy low, and
// o_res holds it until the next result; the receiver cannot stall it, and a new
// start may already be taken in that cycle.
// o_cfg_ready is always high; write configuration only while busy is low.
module variable_increment_counting_bloom (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire vicbf_pkg::t_in                   i_in,
    output vicbf_pkg::t_res                       o_res,
    output logic                                  o_res_strobe,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [vicbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [vicbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vicbf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    vicbf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    vicbf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

    a_emit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_res_strobe)
        else $error("result strobe missing after completion");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr |-> busy)
        else $error("ram sweep while not busy");

    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_res_strobe)
        else $error("result strobe right after a new transaction");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !(o_res.found && o_res.overflow_seen) &&
                         !(o_res.overflow_seen && o_res.underflow_seen))
        else $error("inconsistent result flags");

endmodule

`default_nettype wire

/* hw/rtl/vicbf_ram.sv */
`default_nettype none

module vicbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/vicbf_dp.sv */
`default_nettype none

module vicbf_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire vicbf_pkg::t_in                   i_in,
    input  wire logic                             i_cfg_we,
    input  wire logic [vicbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [vicbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire vicbf_pkg::t_cmd                  i_cmd,
    output vicbf_pkg::t_sts                       o_sts,
    output vicbf_pkg::t_res                       o_res,
    output logic                                  o_res_strobe
);
    import vicbf_pkg::*;

    logic [NFUNC_W-1:0] r_hashes;
    logic [LEXP_W-1:0]  r_lexp;
    logic [NFUNC_W-1:0] w_nfunc;
    logic [LEXP_W-1:0]  w_lexp;
    logic [INC_W-1:0]   w_lvl_mask;
    logic [INC_W-1:0]   w_lvl_bit;
    logic [HASH_W-1:0]  w_f [MAX_HASHES];
    logic [HASH_W-1:0]  w_g [MAX_HASHES];

    logic [1:0]         r_op;
    logic [LEXP_W-1:0]  r_lexp_c;
    logic [IDX_W-1:0]   r_pos [MAX_HASHES];
    logic [INC_W-1:0]   r_inc [MAX_HASHES];
    logic               r_miss;
    logic               r_ovf;
    logic               r_unf;
    t_res               r_res;
    logic               r_strobe;

    logic [CNT_W-1:0]   w_rdata;
    logic [CNT_W:0]     w_sum;
    logic [CNT_W:0]     w_diff;
    logic [CNT_W:0]     w_inc;
    logic               w_fail;
    logic               w_ok;
    logic               w_we;
    logic [IDX_W-1:0]   w_addr;
    logic [CNT_W-1:0]   w_wdata;

    // saturate the live register values
    always_comb begin
        w_nfunc = (r_hashes > NFUNC_W'(MAX_HASHES)) ? NFUNC_W'(MAX_HASHES) : r_hashes;
        if (r_lexp < LEXP_W'(LEXP_MIN)) begin
            w_lexp = LEXP_W'(LEXP_MIN);
        end else if (r_lexp > LEXP_W'(LEXP_MAX)) begin
            w_lexp = LEXP_W'(LEXP_MAX);
        end else begin
            w_lexp = r_lexp;
        end
        w_lvl_bit  = INC_W'(1) << w_lexp;
        w_lvl_mask = w_lvl_bit - INC_W'(1);
    end

    assign w_f[0] = i_in.f_hash_0;
    assign w_f[1] = i_in.f_hash_1;
    assign w_f[2] = i_in.f_hash_2;
    assign w_f[3] = i_in.f_hash_3;
    assign w_g[0] = i_in.g_hash_0;
    assign w_g[1] = i_in.g_hash_1;
    assign w_g[2] = i_in.g_hash_2;
    assign w_g[3] = i_in.g_hash_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hashes <= HASHES_RESET;
            r_lexp   <= LEXP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HASHES_USED:    r_hashes <= NFUNC_W'(i_cfg_data);
                CFG_LEVEL_EXPONENT: r_lexp   <= LEXP_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // counter store is a power of two deep, so the modulo is a bit slice
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_in.func;
            r_lexp_c <= w_lexp;
            for (int i = 0; i < MAX_HASHES; i++) begin
                r_pos[i] <= w_f[i][IDX_W-1:0];
                r_inc[i] <= w_lvl_bit | (w_g[i][INC_W-1:0] & w_lvl_mask);
            end
        end
    end

    always_comb begin
        w_inc  = (CNT_W+1)'(r_inc[i_cmd.sel]);
        w_sum  = {1'b0, w_rdata} + w_inc;
        w_diff = {1'b0, w_rdata} - w_inc;
        // a negative remainder, or one in 1..L-1, means this counter cannot hold the key
        w_fail = w_diff[CNT_W] ||
                 ((w_diff[CNT_W-1:0] != '0) && ((w_diff[CNT_W-1:0] >> r_lexp_c) == '0));
        w_ok   = (r_op == OP_INSERT) ? !w_sum[CNT_W] : !w_diff[CNT_W];
        w_we   = i_cmd.clr || (i_cmd.ex && i_cmd.upd && w_ok);
        w_addr = i_cmd.clr ? i_cmd.clr_addr : r_pos[i_cmd.sel];
        if (i_cmd.clr) begin
            w_wdata = '0;
        end else if (r_op == OP_INSERT) begin
            w_wdata = w_sum[CNT_W-1:0];
        end else begin
            w_wdata = w_diff[CNT_W-1:0];
        end
    end

    vicbf_ram #(
        .WIDTH (CNT_W),
        .DEPTH (COUNTERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss   <= 1'b0;
            r_ovf    <= 1'b0;
            r_unf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.capture) begin
                r_miss <= 1'b0;
                r_ovf  <= 1'b0;
                r_unf  <= 1'b0;
            end else if (i_cmd.ex) begin
                if (!i_cmd.upd) begin
                    r_miss <= r_miss | w_fail;
                end else if (r_op == OP_INSERT) begin
                    r_ovf <= r_ovf | w_sum[CNT_W];
                end else begin
                    r_unf <= r_unf | w_diff[CNT_W];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res.found          <= ((r_op == OP_LOOKUP) || (r_op == OP_REMOVE)) && !r_miss;
            r_res.overflow_seen  <= (r_op == OP_INSERT) && r_ovf;
            r_res.underflow_seen <= (r_op == OP_REMOVE) && r_unf;
        end
    end

    assign o_sts.op     = r_op;
    assign o_sts.nfunc  = w_nfunc;
    assign o_sts.miss   = r_miss;
    assign o_res        = r_res;
    assign o_res_strobe = r_strobe;

endmodule

`default_nettype wire

/* hw/rtl/vicbf_ctrl.sv */
`default_nettype none

module vicbf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    output vicbf_pkg::t_cmd      o_cmd,
    input  wire vicbf_pkg::t_sts i_sts
);
    import vicbf_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLAN,
        ST_READ,
        ST_EXEC,
        ST_TURN,
        ST_DONE
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_clr_addr;
    logic [SEL_W-1:0] r_sel;
    logic             r_upd;
    logic             w_last;

    assign w_last = ({1'b0, r_sel} == (i_sts.nfunc - NFUNC_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_sel      <= '0;
            r_upd      <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + IDX_W'(1);
                    if (r_clr_addr == IDX_W'(COUNTERS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_PLAN;
                    end
                end
                ST_PLAN: begin
                    r_sel <= '0;
                    r_upd <= (i_sts.op == OP_INSERT);
                    if ((i_sts.nfunc == '0) || (i_sts.op == OP_NONE)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (w_last) begin
                        r_state <= ST_TURN;
                    end else begin
                        r_sel   <= r_sel + SEL_W'(1);
                        r_state <= ST_READ;
                    end
                end
                ST_TURN: begin
                    // a remove whose check pass found the key goes on to decrement
                    if (!r_upd && (i_sts.op == OP_REMOVE) && !i_sts.miss) begin
                        r_upd   <= 1'b1;
                        r_sel   <= '0;
                        r_state <= ST_READ;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_cmd.capture  = (r_state == ST_IDLE) && i_start;
    assign o_cmd.clr      = (r_state == ST_CLEAR);
    assign o_cmd.clr_addr = r_clr_addr;
    assign o_cmd.ex       = (r_state == ST_EXEC);
    assign o_cmd.upd      = r_upd;
    assign o_cmd.sel      = r_sel;
    assign o_cmd.emit     = (r_state == ST_DONE);

endmodule

`default_nettype wire

/* bench/variable_increment_counting_bloom_test.sv */
`timescale 1ns / 100ps

class bloom_scoreboard;
    logic [7:0]      counter_store [vicbf_pkg::COUNTERS];
    logic [2:0]      hashes_used;
    logic [2:0]      level_exp;
    vicbf_pkg::t_res expected_flags [$];
    int unsigned     pos_of [4];
    int unsigned     inc_of [4];
    int unsigned     k_now;
    int unsigned     lvl_now;
    int unsigned     mismatches;
    int unsigned     results_seen;
    int unsigned     found_seen;
    int unsigned     overflow_count;
    int unsigned     underflow_count;

    function new();
        foreach (counter_store[i]) counter_store[i] = 8'd0;
        hashes_used     = vicbf_pkg::HASHES_RESET;
        level_exp       = vicbf_pkg::LEXP_RESET;
        mismatches      = 0;
        results_seen    = 0;
        found_seen      = 0;
        overflow_count  = 0;
        underflow_count = 0;
    endfunction

    function void write_reg(logic [vicbf_pkg::CFG_IDX_W-1:0] idx,
                            logic [vicbf_pkg::CFG_DATA_W-1:0] data);
        if (idx == vicbf_pkg::CFG_HASHES_USED) begin
            hashes_used = data;
        end else if (idx == vicbf_pkg::CFG_LEVEL_EXPONENT) begin
            level_exp = data;
        end
    endfunction

    // every function checked against the store as it stands
    function bit lookup_ok();
        int unsigned c;
        for (int i = 0; i < k_now; i++) begin
            c = counter_store[pos_of[i]];
            if (c < inc_of[i]) return 1'b0;
            if (c - inc_of[i] >= 1 && c - inc_of[i] < lvl_now) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void note_item(vicbf_pkg::t_in item);
        logic [63:0]     f [4];
        logic [63:0]     g [4];
        int unsigned     e;
        int unsigned     c;
        vicbf_pkg::t_res flags;
        f[0] = item.f_hash_0;
        f[1] = item.f_hash_1;
        f[2] = item.f_hash_2;
        f[3] = item.f_hash_3;
        g[0] = item.g_hash_0;
        g[1] = item.g_hash_1;
        g[2] = item.g_hash_2;
        g[3] = item.g_hash_3;
        k_now = (hashes_used > vicbf_pkg::MAX_HASHES) ? vicbf_pkg::MAX_HASHES : hashes_used;
        e = level_exp;
        if (e < vicbf_pkg::LEXP_MIN) e = vicbf_pkg::LEXP_MIN;
        if (e > vicbf_pkg::LEXP_MAX) e = vicbf_pkg::LEXP_MAX;
        lvl_now = 1 << e;
        for (int i = 0; i < 4; i++) begin
            pos_of[i] = int'(f[i] % 64'(vicbf_pkg::COUNTERS));
            inc_of[i] = lvl_now + int'(g[i] & 64'(lvl_now - 1));
        end
        flags = '0;
        if (item.func == vicbf_pkg::OP_INSERT) begin
            for (int i = 0; i < k_now; i++) begin
                c = counter_store[pos_of[i]];
                if (255 - inc_of[i] < c) flags.overflow_seen = 1'b1;
                else counter_store[pos_of[i]] = 8'(c + inc_of[i]);
            end
        end else if (item.func == vicbf_pkg::OP_LOOKUP) begin
            flags.found = lookup_ok();
        end else if (item.func == vicbf_pkg::OP_REMOVE) begin
            flags.found = lookup_ok();
            if (flags.found) begin
                for (int i = 0; i < k_now; i++) begin
                    c = counter_store[pos_of[i]];
                    if (c < inc_of[i]) flags.underflow_seen = 1'b1;
                    else counter_store[pos_of[i]] = 8'(c - inc_of[i]);
                end
            end
        end
        expected_flags.push_back(flags);
    endfunction

    function void check_result(vicbf_pkg::t_res got);
        vicbf_pkg::t_res want;
        if (expected_flags.size() == 0) begin
            $error("result with no pending transaction: %b", got);
            mismatches++;
            return;
        end
        want = expected_flags.pop_front();
        results_seen++;
        if (got.found) found_seen++;
        if (got.overflow_seen) overflow_count++;
        if (got.underflow_seen) underflow_count++;
        if (got.found !== want.found) begin
            $error("found: expected %b, actual %b", want.found, got.found);
            mismatches++;
        end
        if (got.overflow_seen !== want.overflow_seen) begin
            $error("overflow_seen: expected %b, actual %b",
                   want.overflow_seen, got.overflow_seen);
            mismatches++;
        end
        if (got.underflow_seen !== want.underflow_seen) begin
            $error("underflow_seen: expected %b, actual %b",
                   want.underflow_seen, got.underflow_seen);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_flags.size();
    endfunction
endclass

module variable_increment_counting_bloom_test;
    import vicbf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_KEYS    = 32;
    localparam int PHASE_ITEMS  = 110;
    localparam int PHASES       = 6;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_in = '0;
    t_res o_res;
    logic o_res_strobe;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bloom_scoreboard board = new();
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    logic [63:0] pool_f [POOL_KEYS][4];
    logic [63:0] pool_g [POOL_KEYS][4];
    logic [2:0]  phase_hashes [PHASES] = '{3'd4, 3'd1, 3'd4, 3'd2, 3'd3, 3'd7};
    logic [2:0]  phase_exp    [PHASES] = '{3'd2, 3'd1, 3'd5, 3'd3, 3'd4, 3'd0};

    variable_increment_counting_bloom DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_in         (i_in),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("variable_increment_counting_bloom_test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) board.check_result(o_res);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in make_item(logic [1:0] op,
                                      logic [63:0] f0, logic [63:0] f1,
                                      logic [63:0] f2, logic [63:0] f3,
                                      logic [63:0] g0, logic [63:0] g1,
                                      logic [63:0] g2, logic [63:0] g3);
        t_in item;
        item.func     = op;
        item.f_hash_0 = f0;
        item.f_hash_1 = f1;
        item.f_hash_2 = f2;
        item.f_hash_3 = f3;
        item.g_hash_0 = g0;
        item.g_hash_1 = g1;
        item.g_hash_2 = g2;
        item.g_hash_3 = g3;
        return item;
    endfunction

    // half the keys land in a handful of counters so they collide
    task automatic fill_pool();
        logic [63:0] h;
        for (int k = 0; k < POOL_KEYS; k++) begin
            for (int i = 0; i < 4; i++) begin
                h = rand64();
                if (k < POOL_KEYS / 2) h[IDX_W-1:0] = IDX_W'($urandom_range(0, 15));
                pool_f[k][i] = h;
                pool_g[k][i] = rand64();
            end
        end
    endtask

    function automatic t_in random_item();
        int unsigned k;
        int unsigned r;
        logic [1:0]  op;
        if ($urandom_range(0, 99) < 75) begin
            k = $urandom_range(0, POOL_KEYS - 1);
            r = $urandom_range(0, 9);
            op = (r < 4) ? OP_INSERT : (r < 7) ? OP_LOOKUP : OP_REMOVE;
            return make_item(op, pool_f[k][0], pool_f[k][1], pool_f[k][2], pool_f[k][3],
                             pool_g[k][0], pool_g[k][1], pool_g[k][2], pool_g[k][3]);
        end
        op = 2'($urandom_range(0, 3));
        return make_item(op, rand64(), rand64(), rand64(), rand64(),
                         rand64(), rand64(), rand64(), rand64());
    endfunction

    // start may be left high from the last transaction; busy keeps it from repeating
    task automatic issue(t_in item);
        int unsigned gap;
        gap = $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= item;
        do @(posedge i_clk); while (busy);
        board.note_item(item);
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [63:0] ones;
        logic [63:0] r0;
        logic [63:0] r1;
        ones = '1;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_HASHES_USED, 3'd4);
        write_reg(CFG_LEVEL_EXPONENT, 3'd2);

        // empty store, then one counter hit by all four functions
        issue(make_item(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(make_item(OP_INSERT, 0, 0, 0, 0, ones, ones, ones, ones));
        issue(make_item(OP_LOOKUP, 0, 0, 0, 0, ones, ones, ones, ones));
        issue(make_item(OP_REMOVE, 0, 0, 0, 0, ones, ones, ones, ones));
        issue(make_item(OP_REMOVE, 0, 0, 0, 0, ones, ones, ones, ones));
        issue(make_item(OP_INSERT, ones, ones, ones, ones, ones, ones, ones, ones));
        issue(make_item(OP_LOOKUP, ones, ones, ones, ones, ones, ones, ones, ones));
        issue(make_item(OP_NONE, ones, ones, ones, ones, ones, ones, ones, ones));
        // lookup passes on each counter alone, the repeated decrement underflows
        issue(make_item(OP_INSERT, 100, 101, 102, 103, 0, 0, 0, 0));
        issue(make_item(OP_REMOVE, 100, 100, 100, 100, 0, 0, 0, 0));
        issue(make_item(OP_LOOKUP, 100, 101, 102, 103, 0, 0, 0, 0));

        write_reg(CFG_LEVEL_EXPONENT, 3'd5);
        issue(make_item(OP_INSERT, 200, 200, 200, 200, ones, ones, ones, ones));
        issue(make_item(OP_INSERT, 200, 200, 200, 200, ones, ones, ones, ones));
        issue(make_item(OP_LOOKUP, 200, 200, 200, 200, ones, ones, ones, ones));
        issue(make_item(OP_REMOVE, 200, 200, 200, 200, 0, 0, 0, 0));

        // no functions in use
        write_reg(CFG_HASHES_USED, 3'd0);
        r0 = rand64();
        r1 = rand64();
        issue(make_item(OP_INSERT, r0, r1, r0, r1, r1, r0, r1, r0));
        issue(make_item(OP_LOOKUP, r0, r1, r0, r1, r1, r0, r1, r0));
        issue(make_item(OP_REMOVE, r0, r1, r0, r1, r1, r0, r1, r0));

        // out-of-range settings saturate
        write_reg(CFG_HASHES_USED, 3'd7);
        write_reg(CFG_LEVEL_EXPONENT, 3'd0);
        issue(make_item(OP_INSERT, 300, 301, 302, 303, r0, r1, r0, r1));
        issue(make_item(OP_LOOKUP, 300, 301, 302, 303, r0, r1, r0, r1));
        write_reg(CFG_HASHES_USED, 3'd5);
        write_reg(CFG_LEVEL_EXPONENT, 3'd6);
        issue(make_item(OP_INSERT, r1, r0, r1, r0, r0, r0, r1, r1));
        issue(make_item(OP_REMOVE, r1, r0, r1, r0, r0, r0, r1, r1));
        write_reg(CFG_HASHES_USED, 3'd1);
        write_reg(CFG_LEVEL_EXPONENT, 3'd7);
        issue(make_item(OP_LOOKUP, r1, r0, r1, r0, r0, r0, r1, r1));

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_HASHES_USED, phase_hashes[p]);
            write_reg(CFG_LEVEL_EXPONENT, phase_exp[p]);
            fill_pool();
            for (int n = 0; n < PHASE_ITEMS; n++) issue(random_item());
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("sent %0d operations over %0d configuration phases plus directed cases",
                 items_sent, PHASES);
        $display("results: %0d checked, %0d found, %0d overflow, %0d underflow",
                 board.results_seen, board.found_seen, board.overflow_count,
                 board.underflow_count);
        if (board.mismatches == 0) begin
            $display("variable_increment_counting_bloom_test passed");
        end else begin
            $display("variable_increment_counting_bloom_test failed");
        end
        $finish;
    end
endmodule
